>>> hdl/sha256_pkg.sv
// Package for the SHA-256 stream hasher: constants, types and round functions.
// Used by the top level, the datapath and the controller; depends on nothing.
`default_nettype none
package sha256_pkg;

    localparam int BlockBytes = 64;
    localparam int LengthPos  = 56;
    localparam logic [7:0] PadByte = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_word;
        logic init_vars;
        logic do_round;
        logic update_chain;
        logic reset_chain;
    } dp_cmd_t;

    localparam logic [31:0] RoundConst [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] InitialHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

>>> hdl/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher: one byte per word in, eight digest words out.
// Bytes are taken only while idle; the 64th byte of a block starts the load, round and update steps.
// A finish pads each final block, compresses one or two blocks, then shows eight digest words,
// one per accepted output word. The round loop, one round per cycle, sets the block time.
// Reset loads the initial hash value and clears the byte and bit counts.
`default_nettype none
module sha256_stream_hasher
    import sha256_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,  // data_byte
    input  wire         s_tuser,  // op
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,  // digest_word, word_index, zero fill
    output logic        m_tlast   // last_word
);

    dp_cmd_t     cmd;
    logic [5:0]  round_idx;
    logic [31:0] load_data;
    logic [2:0]  out_idx;
    logic [31:0] chain_word;

    sha256_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_byte   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_idx   (out_idx),
        .cmd       (cmd),
        .round_idx (round_idx),
        .load_data (load_data)
    );

    sha256_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .round_idx  (round_idx),
        .load_data  (load_data),
        .out_idx    (out_idx),
        .chain_word (chain_word)
    );

    assign m_tdata = {5'd0, out_idx, chain_word};
    assign m_tlast = (out_idx == 3'd7);

endmodule
`default_nettype wire

>>> hdl/sha256_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stands alone; used for the message block buffer.
`default_nettype none
module sha256_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire  [$clog2(Depth)-1:0] waddr,
    input  wire  [Width-1:0]         wdata,
    input  wire  [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> hdl/sha256_datapath.sv
// Datapath of the SHA-256 hasher: schedule window, round registers and chain value.
// Depends on sha256_pkg; driven by commands from sha256_ctrl.
`default_nettype none
module sha256_datapath
    import sha256_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  dp_cmd_t     cmd,
    input  wire  [5:0]  round_idx,
    input  wire  [31:0] load_data,
    input  wire  [2:0]  out_idx,
    output logic [31:0] chain_word
);

    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] h_reg [8];
    logic [31:0] wt;
    logic [31:0] s0;
    logic [31:0] s1;
    logic [31:0] t1;
    logic [31:0] t2;

    always_comb
    begin
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        wt = (round_idx < 6'd16) ? w_reg[0] : (s1 + w_reg[9] + s0 + w_reg[0]);
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
            + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + RoundConst[round_idx] + wt;
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
            + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // Shifts on each load and round; w_reg[0] holds the word for rounds 0 to 15.
    always_ff @(posedge clk)
    begin
        if (cmd.load_word || cmd.do_round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= cmd.load_word ? load_data : wt;
        end
        if (cmd.init_vars)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else if (cmd.do_round)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= InitialHash[i];
            end
        end
        else if (cmd.reset_chain)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= InitialHash[i];
            end
        end
        else if (cmd.update_chain)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
    end

    assign chain_word = h_reg[out_idx];

endmodule
`default_nettype wire

>>> hdl/sha256_ctrl.sv
// Controller of the SHA-256 hasher: byte intake, padding, round sequencing, digest output.
// Depends on sha256_pkg and sha256_ram; commands sha256_datapath.
`default_nettype none
module sha256_ctrl
    import sha256_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire         in_op,
    input  wire  [7:0]  in_byte,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [2:0]  out_idx,
    output dp_cmd_t     cmd,
    output logic [5:0]  round_idx,
    output logic [31:0] load_data
);

    state_t      state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic        fin_reg, fin_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [2:0]  oidx_reg, oidx_next;
    logic        we;
    logic [5:0]  waddr;
    logic [7:0]  wdata;
    logic [5:0]  raddr;
    logic [7:0]  rdata;
    logic [7:0]  len_byte;
    logic [31:0] word_reg;
    logic        accept;

    // The window load assembles each 32-bit word from the buffer's bytes, read through its registered read port.
    sha256_ram #(.Width(8), .Depth(BlockBytes)) u_buf (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign len_byte = bits_reg[63 - 8 * (fill_reg - 6'(LengthPos)) -: 8];

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        bits_next  = bits_reg;
        fin_next   = fin_reg;
        cnt_next   = cnt_reg;
        oidx_next  = oidx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    fill_next = fill_reg + 6'd1;
                    cnt_next  = '0;
                    if (!in_op)
                    begin
                        bits_next = bits_reg + 64'd8;
                        if (fill_reg == 6'(BlockBytes - 1))
                        begin
                            fin_next   = 1'b0;
                            state_next = ST_LOAD;
                        end
                    end
                    else
                    begin
                        fin_next = 1'b1;
                        if (fill_reg == 6'(BlockBytes - 1))
                        begin
                            state_next = ST_LOAD;
                        end
                        else
                        begin
                            state_next = ST_PAD;
                        end
                    end
                end
            end
            ST_PAD:
            begin
                fill_next = fill_reg + 6'd1;
                if (fill_reg == 6'(BlockBytes - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd64)
                begin
                    cnt_next   = '0;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (!fin_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!len_in_blk_reg)
                begin
                    // The length did not fit, so a second padded block follows.
                    state_next = ST_PAD;
                end
                else
                begin
                    oidx_next  = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7)
                    begin
                        bits_next  = '0;
                        fill_next  = '0;
                        fin_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Marks whether the padded block just finished also carries the length field.
    logic len_in_blk_reg, len_in_blk_next;

    always_comb
    begin
        len_in_blk_next = len_in_blk_reg;
        if (state_reg == ST_IDLE && accept && in_op)
        begin
            len_in_blk_next = (fill_reg < 6'(LengthPos));
        end
        else if (state_reg == ST_UPDATE && fin_reg && !len_in_blk_reg)
        begin
            len_in_blk_next = 1'b1;
        end
    end

    always_comb
    begin
        cmd        = '0;
        we         = 1'b0;
        waddr      = fill_reg;
        wdata      = in_byte;
        raddr      = cnt_reg[5:0];
        round_idx  = cnt_reg[5:0];
        out_valid  = 1'b0;
        out_idx    = oidx_reg;
        load_data  = {word_reg[23:0], rdata};
        unique case (state_reg)
            ST_IDLE:
            begin
                we    = accept;
                wdata = in_op ? PadByte : in_byte;
            end
            ST_PAD:
            begin
                we    = 1'b1;
                wdata = (len_in_blk_reg && fill_reg >= 6'(LengthPos)) ? len_byte : 8'h00;
            end
            ST_LOAD:
            begin
                cmd.load_word = (cnt_reg != 7'd0) && (cnt_reg[1:0] == 2'd0);
                cmd.init_vars = (cnt_reg == 7'd0);
            end
            ST_ROUND:
            begin
                cmd.do_round = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.update_chain = 1'b1;
            end
            ST_EMIT:
            begin
                out_valid       = 1'b1;
                cmd.reset_chain = out_ready && (oidx_reg == 3'd7);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= {word_reg[23:0], rdata};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            bits_reg       <= '0;
            fin_reg        <= 1'b0;
            cnt_reg        <= '0;
            oidx_reg       <= '0;
            len_in_blk_reg <= 1'b1;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            bits_reg       <= bits_next;
            fin_reg        <= fin_next;
            cnt_reg        <= cnt_next;
            oidx_reg       <= oidx_next;
            len_in_blk_reg <= len_in_blk_next;
        end
    end

    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_ready && oidx_reg == 3'd7) |=> (state_reg == ST_IDLE))
        else $error("digest did not end after the eighth word");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("input taken while busy");
    a_round_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && cnt_reg == 7'd63) |=> (state_reg == ST_UPDATE))
        else $error("round count mismatch");

endmodule
`default_nettype wire
